// ----- rtl/battery_voltage_to_charge_level_core_macros.svh -----
// Assertion macros shared by the charge level gauge RTL.
`ifndef BATTERY_VOLTAGE_TO_CHARGE_LEVEL_CORE_MACROS_SVH
`define BATTERY_VOLTAGE_TO_CHARGE_LEVEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BVCL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bvcl check failed");
`define BVCL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bvcl check failed");
`else
`define BVCL_ASSERT(label, clk, rst, prop)
`define BVCL_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/bvcl_pkg.sv -----
// Shared types, widths and codes of the charge level gauge.
`timescale 1ns / 1ps
package bvcl_pkg;

   localparam int MAX_POINTS_DEF = 16;

   // field widths
   localparam int VOLT_W   = 13;
   localparam int LEVEL_W  = 7;
   localparam int IDX_W    = 4;
   localparam int CUR_W    = 12;
   localparam int CNT_W    = 5;
   localparam int CAP_W    = 24;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = VOLT_W + LEVEL_W;

   // stream and register port widths
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_FIELDS_W = LEVEL_W + 1 + STATUS_W + CAP_W;
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;

   // serial arithmetic widths
   localparam int PROD_W      = CAP_W + LEVEL_W;
   localparam int DEN_W       = VOLT_W;
   localparam int SHORT_STEPS = VOLT_W + LEVEL_W;

   // constants
   localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 7'd100;
   localparam logic [LEVEL_W-1:0] FULL_THRESHOLD = 7'd95;
   localparam logic [DEN_W-1:0]   PERCENT_DIV    = 13'd100;
   localparam logic [CNT_W-1:0]   POINTS_RESET   = 5'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_POINTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCHARGE_POINTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY         = 2'd2;

   // word kinds
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DISCHARGING = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CHARGING    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_CMUL,
      ST_CDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [CAP_W-1:0]   a;
      logic [LEVEL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic              short_mode;
      logic [PROD_W-1:0] dividend;
      logic [DEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/bvcl_curve_mem.sv -----
// Calibration curve store: both curves in one memory, curve select as address MSB.
`timescale 1ns / 1ps
module bvcl_curve_mem #(
   parameter int  MAX_POINTS = bvcl_pkg::MAX_POINTS_DEF,
   localparam int ADDR_W     = $clog2(MAX_POINTS) + 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [bvcl_pkg::ENTRY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [bvcl_pkg::ENTRY_W-1:0] rd_data
);

   logic [bvcl_pkg::ENTRY_W-1:0] mem [2**ADDR_W];
   logic [bvcl_pkg::ENTRY_W-1:0] rd_data_ff;

   // write one point, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bvcl_mul.sv -----
// Serial shift-add multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
module bvcl_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  bvcl_pkg::mul_req_type req,
   output bvcl_pkg::mul_rsp_type rsp
);

   localparam int STEP_W = $clog2(bvcl_pkg::LEVEL_W + 1);

   logic [bvcl_pkg::PROD_W-1:0]  acc_ff, acc_in;
   logic [bvcl_pkg::CAP_W-1:0]   a_ff, a_in;
   logic [bvcl_pkg::LEVEL_W-1:0] b_ff, b_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   // load operands, then shift-add one bit a cycle
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
         step_in = STEP_W'(bvcl_pkg::LEVEL_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = {acc_ff[bvcl_pkg::PROD_W-2:0], 1'b0}
                 + (b_ff[bvcl_pkg::LEVEL_W-1] ? bvcl_pkg::PROD_W'(a_ff)
                                              : bvcl_pkg::PROD_W'(0));
         b_in    = {b_ff[bvcl_pkg::LEVEL_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      step_ff <= step_in;
   end

   assign rsp.busy    = busy_ff;
   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// ----- rtl/bvcl_div.sv -----
// Serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module bvcl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bvcl_pkg::div_req_type req,
   output bvcl_pkg::div_rsp_type rsp
);

   localparam int NW     = bvcl_pkg::PROD_W;
   localparam int DW     = bvcl_pkg::DEN_W;
   localparam int STEP_W = $clog2(NW + 1);

   logic [DW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DW:0]       trial;
   logic [DW:0]       diff;
   logic              fits;

   // bring down the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         den_in  = req.divisor;
         busy_in = 1'b1;
         if (req.short_mode) begin
            // narrow dividend: left-align it and run fewer steps
            quo_in  = req.dividend << (NW - bvcl_pkg::SHORT_STEPS);
            step_in = STEP_W'(bvcl_pkg::SHORT_STEPS);
         end else begin
            quo_in  = req.dividend;
            step_in = STEP_W'(NW);
         end
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in  = {quo_ff[NW-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- rtl/battery_voltage_to_charge_level_core.sv -----
// Top level of the charge level gauge: register port, segment search sequencer, result word.
// A load word is taken and gives no result; the next word may follow at once.
// A query walks the chosen curve one point per cycle from its block RAM port, then runs the
// shared bit-serial multiplier and divider once, or twice when it interpolates.
// Throughput: one query at a time; the next word is taken once the result is in the output reg.
// Synchronous active-high reset clears control, point counts (to 2) and capacity; curves are not.
`timescale 1ns / 1ps
`include "battery_voltage_to_charge_level_core_macros.svh"
module battery_voltage_to_charge_level_core #(
   parameter int MAX_POINTS = bvcl_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // register write port
   input  logic                            csr_wen,
   input  logic [bvcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvcl_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: curve_select, point_index, point_voltage_mv, point_level, battery_mv,
   //        charger_current, zero fill
   input  logic [bvcl_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: op
   input  logic                            req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: level_percent, is_charging, status, charge_now_uah, zero fill
   output logic [bvcl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int CW     = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = PW + 1;
   localparam int VW     = bvcl_pkg::VOLT_W;
   localparam int LW     = bvcl_pkg::LEVEL_W;
   localparam int NW     = bvcl_pkg::PROD_W;

   // request fields
   logic                          req_curve_sel;
   logic [bvcl_pkg::IDX_W-1:0]    req_point_index;
   logic [VW-1:0]                 req_point_mv;
   logic [LW-1:0]                 req_point_level;
   logic [VW-1:0]                 req_battery_mv;
   logic signed [bvcl_pkg::CUR_W-1:0] req_charger_current;
   logic                          req_accept;
   logic                          query_accept;
   logic                          req_charging;
   logic [bvcl_pkg::CNT_W-1:0]    req_count;
   logic [CW-1:0]                 req_eff;
   logic [PW+bvcl_pkg::IDX_W-1:0] idx_wide;

   // configuration registers
   logic [bvcl_pkg::CNT_W-1:0] charge_pts_ff, discharge_pts_ff;
   logic [bvcl_pkg::CAP_W-1:0] capacity_ff;

   // curve store
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;
   logic [bvcl_pkg::ENTRY_W-1:0] rd_data;
   logic [VW-1:0]                rd_volt;
   logic [LW-1:0]                rd_level;

   // sequencer state
   bvcl_pkg::state_type state_ff, state_in;
   logic [VW-1:0]                 mv_ff, mv_in;
   logic                          charging_ff, charging_in;
   logic [CW-1:0]                 eff_ff, eff_in;
   logic [CW-1:0]                 ptr_ff, ptr_in;
   logic [bvcl_pkg::ENTRY_W-1:0]  prev_ff, prev_in;
   logic [LW-1:0]                 l0_ff, l0_in;
   logic                          rise_ff, rise_in;
   logic [VW-1:0]                 den_ff, den_in;
   logic [LW-1:0]                 level_ff, level_in;
   logic [bvcl_pkg::CAP_W-1:0]    charge_ff, charge_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [bvcl_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // segment evaluation
   logic [VW-1:0]  v0;
   logic [LW-1:0]  l0;
   logic           first_above;
   logic [LW-1:0]  first_level;
   logic           seg_hit;
   logic           seg_flat;
   logic [LW-1:0]  flat_level;
   logic           scan_end;
   logic           seg_rise;
   logic [LW-1:0]  seg_dl;
   logic [VW-1:0]  seg_dv;
   logic [NW:0]    up_sum;
   logic [NW-1:0]  l0_wide;
   logic [NW-1:0]  dn_diff;
   logic [LW-1:0]  interp_level;
   logic           rsp_free;
   logic [bvcl_pkg::STATUS_W-1:0] status_val;

   // arithmetic units
   bvcl_pkg::mul_req_type mul_req;
   bvcl_pkg::mul_rsp_type mul_rsp;
   bvcl_pkg::div_req_type div_req;
   bvcl_pkg::div_rsp_type div_rsp;

   // unpack the request word
   assign req_curve_sel       = req_tdata[0];
   assign req_point_index     = req_tdata[4:1];
   assign req_point_mv        = req_tdata[17:5];
   assign req_point_level     = req_tdata[24:18];
   assign req_battery_mv      = req_tdata[37:25];
   assign req_charger_current = $signed(req_tdata[49:38]);

   assign req_tready   = (state_ff == bvcl_pkg::ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign query_accept = req_accept && (req_tuser == bvcl_pkg::OP_QUERY);
   assign req_charging = (req_charger_current != '0)
                       && !req_charger_current[bvcl_pkg::CUR_W-1];

   // limit the point count to the curve depth
   assign req_count = req_charging ? charge_pts_ff : discharge_pts_ff;
   assign req_eff   = (32'(req_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(req_count);

   // write points straight from the request; drop indexes beyond the depth
   assign idx_wide = (PW + bvcl_pkg::IDX_W)'(req_point_index);
   assign wr_en    = req_accept && (req_tuser == bvcl_pkg::OP_LOAD)
                   && (32'(req_point_index) < MAX_POINTS);
   assign wr_addr  = {req_curve_sel, idx_wide[PW-1:0]};

   // point 0 is read on accept, later points from the walk pointer
   assign rd_addr = (state_ff == bvcl_pkg::ST_IDLE) ? {req_charging, PW'(0)}
                                                    : {charging_ff, ptr_ff[PW-1:0]};

   bvcl_curve_mem #(
      .MAX_POINTS (MAX_POINTS)
   ) u_curve_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_point_mv, req_point_level}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bvcl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   bvcl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // evaluate point 0 and the current segment
   assign rd_volt     = rd_data[bvcl_pkg::ENTRY_W-1:LW];
   assign rd_level    = rd_data[LW-1:0];
   assign v0          = prev_ff[bvcl_pkg::ENTRY_W-1:LW];
   assign l0          = prev_ff[LW-1:0];
   assign first_above = (mv_ff > rd_volt);
   assign first_level = (rd_level > bvcl_pkg::LEVEL_MAX) ? bvcl_pkg::LEVEL_MAX : rd_level;
   assign seg_hit     = (mv_ff <= v0) && (mv_ff >= rd_volt);
   assign seg_flat    = (v0 == rd_volt);
   assign flat_level  = (l0 > bvcl_pkg::LEVEL_MAX) ? bvcl_pkg::LEVEL_MAX : l0;
   assign scan_end    = (ptr_ff >= eff_ff);
   assign seg_rise    = (l0 < rd_level);
   assign seg_dl      = seg_rise ? (rd_level - l0) : (l0 - rd_level);
   assign seg_dv      = v0 - mv_ff;

   // apply the signed step to the upper level and saturate
   assign up_sum  = (NW + 1)'(l0_ff) + (NW + 1)'(div_rsp.quotient);
   assign l0_wide = NW'(l0_ff);
   assign dn_diff = l0_wide - div_rsp.quotient;

   always_comb begin
      if (rise_ff) begin
         interp_level = (up_sum > (NW + 1)'(bvcl_pkg::LEVEL_MAX)) ? bvcl_pkg::LEVEL_MAX
                                                                  : up_sum[LW-1:0];
      end else if (div_rsp.quotient > l0_wide) begin
         interp_level = '0;
      end else begin
         interp_level = (dn_diff > NW'(bvcl_pkg::LEVEL_MAX)) ? bvcl_pkg::LEVEL_MAX
                                                             : dn_diff[LW-1:0];
      end
   end

   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign status_val = (level_ff > bvcl_pkg::FULL_THRESHOLD) ? bvcl_pkg::STATUS_FULL
                     : (charging_ff ? bvcl_pkg::STATUS_CHARGING
                                    : bvcl_pkg::STATUS_DISCHARGING);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bvcl_pkg::ST_IDLE: begin
            if (query_accept) state_in = bvcl_pkg::ST_FIRST;
         end
         bvcl_pkg::ST_FIRST: begin
            if (first_above || (eff_ff < CW'(2))) state_in = bvcl_pkg::ST_CMUL;
            else state_in = bvcl_pkg::ST_SCAN;
         end
         bvcl_pkg::ST_SCAN: begin
            priority if (seg_hit && seg_flat) state_in = bvcl_pkg::ST_CMUL;
            else if (seg_hit) state_in = bvcl_pkg::ST_MUL;
            else if (scan_end) state_in = bvcl_pkg::ST_CMUL;
         end
         bvcl_pkg::ST_MUL: begin
            if (mul_rsp.done) state_in = bvcl_pkg::ST_DIV;
         end
         bvcl_pkg::ST_DIV: begin
            if (div_rsp.done) state_in = bvcl_pkg::ST_CMUL;
         end
         bvcl_pkg::ST_CMUL: begin
            if (mul_rsp.done) state_in = bvcl_pkg::ST_CDIV;
         end
         bvcl_pkg::ST_CDIV: begin
            if (div_rsp.done) state_in = bvcl_pkg::ST_DONE;
         end
         bvcl_pkg::ST_DONE: begin
            if (rsp_free) state_in = bvcl_pkg::ST_IDLE;
         end
         default: state_in = bvcl_pkg::ST_IDLE;
      endcase
   end

   // datapath controls and unit requests
   always_comb begin
      mv_in         = mv_ff;
      charging_in   = charging_ff;
      eff_in        = eff_ff;
      ptr_in        = ptr_ff;
      prev_in       = prev_ff;
      l0_in         = l0_ff;
      rise_in       = rise_ff;
      den_in        = den_ff;
      level_in      = level_ff;
      charge_in     = charge_ff;
      mul_req       = '0;
      div_req       = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         bvcl_pkg::ST_IDLE: begin
            if (query_accept) begin
               mv_in       = req_battery_mv;
               charging_in = req_charging;
               eff_in      = req_eff;
               ptr_in      = CW'(1);
            end
         end
         bvcl_pkg::ST_FIRST: begin
            priority if (first_above) begin
               level_in      = first_level;
               mul_req.start = 1'b1;
               mul_req.a     = capacity_ff;
               mul_req.b     = first_level;
            end else if (eff_ff < CW'(2)) begin
               level_in      = '0;
               mul_req.start = 1'b1;
               mul_req.a     = capacity_ff;
            end else begin
               prev_in = rd_data;
               ptr_in  = ptr_ff + CW'(1);
            end
         end
         bvcl_pkg::ST_SCAN: begin
            priority if (seg_hit && seg_flat) begin
               level_in      = flat_level;
               mul_req.start = 1'b1;
               mul_req.a     = capacity_ff;
               mul_req.b     = flat_level;
            end else if (seg_hit) begin
               // step magnitude = (v0 - mv) * |l0 - l1| / (v0 - v1)
               l0_in         = l0;
               rise_in       = seg_rise;
               den_in        = v0 - rd_volt;
               mul_req.start = 1'b1;
               mul_req.a     = bvcl_pkg::CAP_W'(seg_dv);
               mul_req.b     = seg_dl;
            end else if (scan_end) begin
               level_in      = '0;
               mul_req.start = 1'b1;
               mul_req.a     = capacity_ff;
            end else begin
               prev_in = rd_data;
               ptr_in  = ptr_ff + CW'(1);
            end
         end
         bvcl_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               div_req.start      = 1'b1;
               div_req.short_mode = 1'b1;
               div_req.dividend   = mul_rsp.product;
               div_req.divisor    = den_ff;
            end
         end
         bvcl_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               level_in      = interp_level;
               mul_req.start = 1'b1;
               mul_req.a     = capacity_ff;
               mul_req.b     = interp_level;
            end
         end
         bvcl_pkg::ST_CMUL: begin
            if (mul_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = mul_rsp.product;
               div_req.divisor  = bvcl_pkg::PERCENT_DIV;
            end
         end
         bvcl_pkg::ST_CDIV: begin
            if (div_rsp.done) charge_in = div_rsp.quotient[bvcl_pkg::CAP_W-1:0];
         end
         bvcl_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{bvcl_pkg::RSP_PAD_W{1'b0}}, charge_ff, status_val,
                                charging_ff, level_ff};
            end
         end
         default: begin
            rsp_tdata_in = rsp_tdata_ff;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_pts_ff    <= bvcl_pkg::POINTS_RESET;
         discharge_pts_ff <= bvcl_pkg::POINTS_RESET;
         capacity_ff      <= '0;
      end else if (csr_wen) begin
         if (csr_index == bvcl_pkg::CSR_CHARGE_POINTS) begin
            charge_pts_ff <= csr_wdata[bvcl_pkg::CNT_W-1:0];
         end
         if (csr_index == bvcl_pkg::CSR_DISCHARGE_POINTS) begin
            discharge_pts_ff <= csr_wdata[bvcl_pkg::CNT_W-1:0];
         end
         if (csr_index == bvcl_pkg::CSR_CAPACITY) begin
            capacity_ff <= csr_wdata[bvcl_pkg::CAP_W-1:0];
         end
      end
   end

   // sequencer and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bvcl_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mv_ff        <= mv_in;
      charging_ff  <= charging_in;
      eff_ff       <= eff_in;
      ptr_ff       <= ptr_in;
      prev_ff      <= prev_in;
      l0_ff        <= l0_in;
      rise_ff      <= rise_in;
      den_ff       <= den_in;
      level_ff     <= level_in;
      charge_ff    <= charge_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `BVCL_ASSERT_ALWAYS(a_reset_clears_rsp, clock, $past(reset) |-> !rsp_tvalid_ff)
   `BVCL_ASSERT(a_idle_units_quiet, clock, reset, (state_ff == bvcl_pkg::ST_IDLE) |-> (!mul_rsp.busy && !div_rsp.busy))
   `BVCL_ASSERT(a_mul_start_free, clock, reset, mul_req.start |-> !mul_rsp.busy)
   `BVCL_ASSERT(a_interp_to_charge, clock, reset, (state_ff == bvcl_pkg::ST_DIV && div_rsp.done) |=> (state_ff == bvcl_pkg::ST_CMUL))
   `BVCL_ASSERT(a_level_range, clock, reset, rsp_tvalid_ff |-> (rsp_tdata_ff[6:0] <= bvcl_pkg::LEVEL_MAX))
   `BVCL_ASSERT(a_full_status, clock, reset, rsp_tvalid_ff |-> ((rsp_tdata_ff[9:8] == bvcl_pkg::STATUS_FULL) == (rsp_tdata_ff[6:0] > bvcl_pkg::FULL_THRESHOLD)))

endmodule
